>>> rtl/lppd_pkg.sv
`timescale 1ns / 1ps

package lppd_pkg;

    localparam logic [31:0] MAGIC_AT_RESET = 32'h0100_C633;

    // config port: byte addresses, one 32-bit register
    localparam int          ADDR_W     = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAGIC = 3'd0;

    // header is 4 magic bytes then 4 length bytes, little-endian
    localparam logic [2:0]  HDR_LAST   = 3'd7;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_BAD_MAGIC = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

endpackage

>>> rtl/length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps

// Byte-stream packet deframer. Each packet is an 8-byte header (32-bit magic,
// then 32-bit payload length, both little-endian) followed by that many
// payload bytes. Header bytes give no output word; each payload byte gives one
// word with o_last on the final byte. A zero length gives one empty-packet
// word, and a magic that differs from the expected_magic register (byte
// address 0, reset 0x0100C633) gives one error word, after which the next byte
// starts a new header. Throughput is one byte per clock while o_stall is low:
// a byte is held in the input register, the parser updates its header/count
// state from it, and the result lands in a two-word output queue, so each word
// passes the input register and then the output queue on its way to o_valid.
// o_stall rises only when the output queue is full and a byte is waiting.
module length_prefixed_packet_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_in_byte,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_out_byte,
    output logic [1:0]                  o_kind,
    output logic                        o_last,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lppd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [31:0]       magic;
    logic              q_full;
    logic              step;
    logic              push;
    lppd_pkg::t_result result;
    lppd_pkg::t_result out_word;

    assign o_stall = r_in_valid && q_full;
    assign step    = r_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    lppd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_magic (magic)
    );

    lppd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_magic  (magic),
        .o_push   (push),
        .o_result (result)
    );

    lppd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_word)
    );

    assign o_out_byte = out_word.data;
    assign o_kind     = out_word.kind;
    assign o_last     = out_word.last;

endmodule

>>> rtl/lppd_regs.sv
`timescale 1ns / 1ps

module lppd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lppd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [31:0]                 o_magic
);

    logic [31:0] r_magic;
    logic        wr_magic;

    assign wr_magic = psel && penable && pwrite && (paddr == lppd_pkg::ADDR_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= lppd_pkg::MAGIC_AT_RESET;
        end else if (wr_magic) begin
            r_magic <= pwdata;
        end
    end

    assign prdata  = (paddr == lppd_pkg::ADDR_MAGIC) ? r_magic : 32'd0;
    assign pready  = 1'b1;
    assign o_magic = r_magic;

endmodule

>>> rtl/lppd_parse.sv
`timescale 1ns / 1ps

module lppd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_magic,
    output logic              o_push,
    output lppd_pkg::t_result o_result
);

    logic [2:0]  r_hdr_idx,   n_hdr_idx;
    logic [55:0] r_hdr,       n_hdr;     // first seven header bytes
    logic        r_in_payload, n_in_payload;
    logic [31:0] r_remaining, n_remaining;
    logic [31:0] length;

    assign length = {i_byte, r_hdr[55:32]};

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_hdr        = r_hdr;
        n_in_payload = r_in_payload;
        n_remaining  = r_remaining;
        o_push       = 1'b0;
        o_result     = '{data: 8'd0, kind: lppd_pkg::KIND_PAYLOAD, last: 1'b0};
        if (i_step) begin
            if (r_in_payload) begin
                o_push        = 1'b1;
                o_result.data = i_byte;
                o_result.last = (r_remaining <= 32'd1);
                n_remaining   = r_remaining - 32'd1;
                if (o_result.last) begin
                    n_in_payload = 1'b0;
                    n_remaining  = 32'd0;
                    n_hdr_idx    = 3'd0;
                    n_hdr        = '0;
                end
            end else if (r_hdr_idx != lppd_pkg::HDR_LAST) begin
                n_hdr     = r_hdr | ({48'd0, i_byte} << {r_hdr_idx, 3'b000});
                n_hdr_idx = r_hdr_idx + 3'd1;
            end else begin
                // eighth header byte: check magic, then length
                n_hdr_idx     = 3'd0;
                n_hdr         = '0;
                o_push        = 1'b1;
                o_result.last = 1'b1;
                if (r_hdr[31:0] != i_magic) begin
                    o_result.kind = lppd_pkg::KIND_BAD_MAGIC;
                end else if (length == 32'd0) begin
                    o_result.kind = lppd_pkg::KIND_EMPTY;
                end else begin
                    o_push       = 1'b0;
                    n_in_payload = 1'b1;
                    n_remaining  = length;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= 3'd0;
            r_hdr        <= '0;
            r_in_payload <= 1'b0;
            r_remaining  <= 32'd0;
        end else begin
            r_hdr_idx    <= n_hdr_idx;
            r_hdr        <= n_hdr;
            r_in_payload <= n_in_payload;
            r_remaining  <= n_remaining;
        end
    end

`ifndef SYNTHESIS
    a_payload_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_idx == 3'd0))
        else $error("header index nonzero during payload");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_remaining != 32'd0))
        else $error("payload active with no bytes remaining");

    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_result.kind != lppd_pkg::KIND_PAYLOAD))
            |-> (o_result.last && (o_result.data == 8'd0)))
        else $error("empty or error word malformed");

    a_header_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_payload && (r_hdr_idx != lppd_pkg::HDR_LAST)) |-> !o_push)
        else $error("word emitted mid-header");
`endif

endmodule

>>> rtl/lppd_outq.sv
`timescale 1ns / 1ps

module lppd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lppd_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output lppd_pkg::t_result o_result
);

    // e0 is the head shown on the port, e1 the skid slot
    lppd_pkg::t_result r_e0, n_e0, r_e1, n_e1;
    logic              r_v0, n_v0, r_v1, n_v1;
    logic              pop;

    assign pop = r_v0 && !i_stall;

    always_comb begin
        n_e0 = r_e0;
        n_e1 = r_e1;
        n_v0 = r_v0;
        n_v1 = r_v1;
        if (pop) begin
            n_e0 = r_e1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_e0 = i_result;
                n_v0 = 1'b1;
            end else begin
                n_e1 = i_result;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

    assign o_full   = r_v1;
    assign o_valid  = r_v0;
    assign o_result = r_e0;

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("skid slot filled with empty head");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !i_push)
        else $error("push into full queue");
`endif

endmodule
